### hdl/button_click_classifier_core_assert.svh
// Assertion macros for the button click classifier.
// Included by the RTL files that check their own logic; no other dependencies.
`ifndef BUTTON_CLICK_CLASSIFIER_CORE_ASSERT_SVH
`define BUTTON_CLICK_CLASSIFIER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define BCC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define BCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/bcc_pkg.sv
// Shared types and constants for the button click classifier.
// No dependencies; imported by every module of the block.
`default_nettype none

package bcc_pkg;

  // Age counter width default and configuration register width
  localparam int AGE_WIDTH_DEF = 16;
  localparam int CFG_W         = 15;

  // Configuration reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_DEF = CFG_W'(50);
  localparam logic [CFG_W-1:0] GAP_DEF      = CFG_W'(260);
  localparam logic [CFG_W-1:0] LONG_DEF     = CFG_W'(2000);

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_ENABLE   = 2'd0,
    CFG_DEBOUNCE = 2'd1,
    CFG_GAP      = 2'd2,
    CFG_LONG     = 2'd3
  } cfg_idx_e;

  // Reported event codes
  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } click_ev_e;

  // Current configuration handed to the classifier
  typedef struct packed {
    logic             enable;
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] gap_ticks;
    logic [CFG_W-1:0] long_ticks;
  } cfg_t;

endpackage

`default_nettype wire

### hdl/bcc_cfg_regs.sv
// Configuration register file of the button click classifier.
// Depends on bcc_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module bcc_cfg_regs
  import bcc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_idx_i,
  input  wire logic [CFG_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the write into the addressed register
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ENABLE:   cfg_d.enable         = cfg_wdata_i[0];
        CFG_DEBOUNCE: cfg_d.debounce_ticks = cfg_wdata_i;
        CFG_GAP:      cfg_d.gap_ticks      = cfg_wdata_i;
        CFG_LONG:     cfg_d.long_ticks     = cfg_wdata_i;
        default:      cfg_d                = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable         <= 1'b0;
      cfg_q.debounce_ticks <= DEBOUNCE_DEF;
      cfg_q.gap_ticks      <= GAP_DEF;
      cfg_q.long_ticks     <= LONG_DEF;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### hdl/bcc_classifier.sv
// Debounce and click classification state with its one-tick update.
// Depends on bcc_pkg and on the assertion macro header.
`default_nettype none

`include "button_click_classifier_core_assert.svh"

module bcc_classifier
  import bcc_pkg::*;
#(
  parameter int AGE_WIDTH = AGE_WIDTH_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cfg_t       cfg_i,
  input  wire logic       upd_i,      // commit one tick
  input  wire logic       pin_i,      // sampled pin, low means pressed
  output logic [1:0]      event_o,
  output logic            stable_o
);

  logic                 raw_pressed_q, raw_pressed_d;
  logic                 deb_pressed_q, deb_pressed_d;
  logic [AGE_WIDTH-1:0] raw_age_q, raw_age_d;
  logic [AGE_WIDTH-1:0] press_age_q, press_age_d;
  logic [AGE_WIDTH-1:0] rel_age_q, rel_age_d;
  logic                 long_fired_q, long_fired_d;
  logic                 awaiting_q, awaiting_d;
  click_ev_e            ev;
  logic                 raw;

  function automatic logic [AGE_WIDTH-1:0] sat_inc(input logic [AGE_WIDTH-1:0] a);
    return (&a) ? a : a + 1'b1;
  endfunction

  // When enabled, advance ages, debounce, then double click, long press and single click timeout
  always_comb begin
    raw           = ~pin_i;
    raw_pressed_d = raw_pressed_q;
    deb_pressed_d = deb_pressed_q;
    raw_age_d     = raw_age_q;
    press_age_d   = press_age_q;
    rel_age_d     = rel_age_q;
    long_fired_d  = long_fired_q;
    awaiting_d    = awaiting_q;
    ev            = EV_NONE;
    if (cfg_i.enable) begin
      raw_age_d   = sat_inc(raw_age_q);
      press_age_d = sat_inc(press_age_q);
      rel_age_d   = sat_inc(rel_age_q);

      if (raw != raw_pressed_q) begin
        raw_pressed_d = raw;
        raw_age_d     = '0;
      end

      if (raw_age_d >= AGE_WIDTH'(cfg_i.debounce_ticks) && raw != deb_pressed_q) begin
        deb_pressed_d = raw;
        if (raw) begin
          press_age_d  = '0;
          long_fired_d = 1'b0;
        end else if (!long_fired_q) begin
          if (awaiting_q && rel_age_d <= AGE_WIDTH'(cfg_i.gap_ticks)) begin
            awaiting_d = 1'b0;
            ev         = EV_DOUBLE;
          end else begin
            awaiting_d = 1'b1;
            rel_age_d  = '0;
          end
        end
      end

      if (deb_pressed_d && !long_fired_d &&
          press_age_d >= AGE_WIDTH'(cfg_i.long_ticks)) begin
        long_fired_d = 1'b1;
        awaiting_d   = 1'b0;
        ev           = EV_LONG;
      end

      if (awaiting_d && !deb_pressed_d && rel_age_d > AGE_WIDTH'(cfg_i.gap_ticks)) begin
        awaiting_d = 1'b0;
        ev         = EV_SINGLE;
      end
    end
  end

  // Commit state only when a tick leaves the input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_pressed_q <= 1'b0;
      deb_pressed_q <= 1'b0;
      raw_age_q     <= '1;
      press_age_q   <= '1;
      rel_age_q     <= '1;
      long_fired_q  <= 1'b0;
      awaiting_q    <= 1'b0;
    end else if (upd_i) begin
      raw_pressed_q <= raw_pressed_d;
      deb_pressed_q <= deb_pressed_d;
      raw_age_q     <= raw_age_d;
      press_age_q   <= press_age_d;
      rel_age_q     <= rel_age_d;
      long_fired_q  <= long_fired_d;
      awaiting_q    <= awaiting_d;
    end
  end

  assign event_o  = ev;
  assign stable_o = deb_pressed_d;

  `BCC_ASSERT_NEXT(a_long_sets_fired, clk_i, rst_ni, upd_i && ev == EV_LONG,
                   long_fired_q, "long press without fired flag")
  `BCC_ASSERT_IMPL(a_double_needs_wait, clk_i, rst_ni, upd_i && ev == EV_DOUBLE,
                   awaiting_q, "double click with no pending release")
  `BCC_ASSERT_NEXT(a_disabled_frozen, clk_i, rst_ni, upd_i && !cfg_i.enable,
                   raw_age_q == $past(raw_age_q) && rel_age_q == $past(rel_age_q),
                   "state moved while disabled")

endmodule

`default_nettype wire

### hdl/button_click_classifier_core.sv
// Top level of the button click classifier: stream handshake and pipeline registers.
// Depends on bcc_pkg, bcc_cfg_regs and bcc_classifier.
`default_nettype none

// Takes one beat per millisecond tick carrying the sampled active-low button
// pin and returns one beat per tick with the click event (none, single,
// double, long press) and the debounced level. One beat is accepted every
// clock cycle while the result side does not stall; a beat waits in the
// input register, the state update runs in a single combinational pass,
// and the result is held in an output register. Backpressure on the result
// side stalls the input register only when the output register is still
// occupied. Configuration writes take effect on the next cycle and are meant
// to be made while no beat is in flight.
module button_click_classifier_core
  import bcc_pkg::*;
#(
  parameter int AGE_WIDTH = AGE_WIDTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // Configuration write port
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_idx_i,
  input  wire logic [CFG_W-1:0] cfg_wdata_i,
  // Input stream
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [7:0]       s_axis_tdata,   // [0] pin_level, [7:1] zero
  // Result stream
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic [7:0]            m_axis_tdata    // [1:0] click_event, [2] stable_pressed
);

  cfg_t       cfg;
  logic       in_valid_q, in_valid_d;
  logic       pin_q;
  logic       out_valid_q, out_valid_d;
  logic [1:0] out_ev_q;
  logic       out_stable_q;
  logic       advance, upd, s_acc;
  logic [1:0] ev;
  logic       stable;

  bcc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bcc_classifier #(
    .AGE_WIDTH (AGE_WIDTH)
  ) u_cls (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .upd_i    (upd),
    .pin_i    (pin_q),
    .event_o  (ev),
    .stable_o (stable)
  );

  // Handshake: move forward whenever the output register is free or drains
  assign advance       = !out_valid_q || m_axis_tready;
  assign upd           = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_acc) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = in_valid_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      pin_q <= s_axis_tdata[0];
    end
    if (upd) begin
      out_ev_q     <= ev;
      out_stable_q <= stable;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_stable_q, out_ev_q};

endmodule

`default_nettype wire

### bench/bcc_click_checker.sv
// Result checker for the button click classifier: mirrors config writes, predicts each tick.
// Depends on bcc_pkg; instantiated by button_click_classifier_core_tb beside the block.
module bcc_click_checker
  import bcc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [7:0]       in_data_i,    // [0] pin_level, [7:1] zero
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [7:0]       out_data_i,   // [1:0] click_event, [2] stable_pressed
  output int               fail_count_o,
  output int               pending_o,
  output int               checked_o,
  output int               singles_o,
  output int               doubles_o,
  output int               longs_o
);

  localparam int AGE_W = AGE_WIDTH_DEF;
  localparam logic [AGE_W-1:0] AGE_SAT = '1;

  typedef struct packed {
    click_ev_e ev;
    logic      pressed;
  } click_res_t;

  // Mirrored configuration
  logic             en_q;
  logic [CFG_W-1:0] deb_q, gap_q, long_q;

  // Classifier state
  logic             raw_q, stable_q, long_done_q, await_q;
  logic [AGE_W-1:0] raw_age_q, press_age_q, release_age_q;

  click_res_t expected_clicks[$];
  int         mismatches, checked, singles, doubles, longs;

  assign fail_count_o = mismatches;
  assign checked_o    = checked;
  assign singles_o    = singles;
  assign doubles_o    = doubles;
  assign longs_o      = longs;

  function automatic logic [AGE_W-1:0] age_step(input logic [AGE_W-1:0] age);
    return (age == AGE_SAT) ? age : age + 1'b1;
  endfunction

  // Advance the classifier by one tick and return the result it reports
  function automatic click_res_t classify_tick(input logic pin);
    click_res_t res;
    logic       pressed;
    res.ev  = EV_NONE;
    pressed = ~pin;
    if (en_q) begin
      raw_age_q     = age_step(raw_age_q);
      press_age_q   = age_step(press_age_q);
      release_age_q = age_step(release_age_q);
      if (pressed != raw_q) begin
        raw_q     = pressed;
        raw_age_q = '0;
      end
      // Take the raw level once it has been steady long enough
      if (raw_age_q >= deb_q && pressed != stable_q) begin
        stable_q = pressed;
        if (pressed) begin
          press_age_q = '0;
          long_done_q = 1'b0;
        end else if (!long_done_q) begin
          if (await_q && release_age_q <= gap_q) begin
            await_q = 1'b0;
            res.ev  = EV_DOUBLE;
          end else begin
            await_q       = 1'b1;
            release_age_q = '0;
          end
        end
      end
      if (stable_q && !long_done_q && press_age_q >= long_q) begin
        long_done_q = 1'b1;
        await_q     = 1'b0;
        res.ev      = EV_LONG;
      end
      // Second release never came within the gap
      if (await_q && !stable_q && release_age_q > gap_q) begin
        await_q = 1'b0;
        res.ev  = EV_SINGLE;
      end
    end
    res.pressed = stable_q;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    click_res_t want;
    click_ev_e  got_ev;
    logic       got_pressed;
    if (!rst_ni) begin
      en_q          <= 1'b0;
      deb_q         <= DEBOUNCE_DEF;
      gap_q         <= GAP_DEF;
      long_q        <= LONG_DEF;
      raw_q         <= 1'b0;
      stable_q      <= 1'b0;
      long_done_q   <= 1'b0;
      await_q       <= 1'b0;
      raw_age_q     <= AGE_SAT;
      press_age_q   <= AGE_SAT;
      release_age_q <= AGE_SAT;
      expected_clicks.delete();
      mismatches    <= 0;
      checked       <= 0;
      singles       <= 0;
      doubles       <= 0;
      longs         <= 0;
      pending_o     <= 0;
    end else begin
      // Mirror register writes
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_ENABLE:   en_q   = cfg_wdata_i[0];
          CFG_DEBOUNCE: deb_q  = cfg_wdata_i;
          CFG_GAP:      gap_q  = cfg_wdata_i;
          CFG_LONG:     long_q = cfg_wdata_i;
          default: ;
        endcase
      end
      // Compare a result beat against the oldest prediction
      if (out_valid_i && out_ready_i) begin
        got_ev      = click_ev_e'(out_data_i[1:0]);
        got_pressed = out_data_i[2];
        if (expected_clicks.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("unexpected result beat: event %s pressed %0b", got_ev.name(), got_pressed);
        end else begin
          want    = expected_clicks.pop_front();
          checked = checked + 1;
          case (want.ev)
            EV_SINGLE: singles = singles + 1;
            EV_DOUBLE: doubles = doubles + 1;
            EV_LONG:   longs   = longs + 1;
            default: ;
          endcase
          if (got_ev != want.ev || got_pressed != want.pressed) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("result %0d mismatch: expected event %s pressed %0b, got event %s pressed %0b",
                       checked, want.ev.name(), want.pressed, got_ev.name(), got_pressed);
          end
        end
      end
      // Predict the result of an accepted tick
      if (in_valid_i && in_ready_i)
        expected_clicks.push_back(classify_tick(in_data_i[0]));
      pending_o <= expected_clicks.size();
    end
  end

endmodule

### bench/button_click_classifier_core_tb.sv
// Testbench top for button_click_classifier_core: clock, reset, tick stimulus and verdict.
// Depends on bcc_pkg, the block itself and bcc_click_checker, which predicts and compares.
module button_click_classifier_core_tb;
  import bcc_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int TIMEOUT     = 3_000_000;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_TICKS = 290;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             cfg_we        = 1'b0;
  cfg_idx_e         cfg_idx       = CFG_ENABLE;
  logic [CFG_W-1:0] cfg_wdata     = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata  = 8'h01;   // [0] pin_level, [7:1] zero
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [7:0]       m_axis_tdata;            // [1:0] click_event, [2] stable_pressed

  int fail_count, pending, checked, singles, doubles, longs;
  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_req  = 0;
  int hold_ack  = 0;
  int hold_left = 0;
  int ticks_sent      = 0;
  int settings_loaded = 0;

  // Shaping values for the random gestures
  int cur_deb, cur_gap, cur_long;

  always #5 clk_i = ~clk_i;

  button_click_classifier_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  bcc_click_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .singles_o    (singles),
    .doubles_o    (doubles),
    .longs_o      (longs)
  );

  // Count down a requested receiver hold-off
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: stall at random, hold off entirely while the countdown runs
  always @(posedge clk_i)
    m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);

  initial begin
    #(TIMEOUT);
    $display("status: fail");
    $finish;
  end

  // Offer count beats of one pin level, with random sender gaps
  task automatic send_ticks(input logic pin, input int unsigned count);
    repeat (count) begin
      while ($urandom_range(99) < idle_pct) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= {7'd0, pin};
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
      ticks_sent++;
    end
  endtask

  // Stop offering and wait for every predicted result to come back
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Write all four registers back to back; call only while idle
  task automatic load_settings(input logic en, input int deb, input int gap, input int lng);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_ENABLE;
    cfg_wdata <= CFG_W'(en);
    @(posedge clk_i);
    cfg_idx   <= CFG_DEBOUNCE;
    cfg_wdata <= CFG_W'(deb);
    @(posedge clk_i);
    cfg_idx   <= CFG_GAP;
    cfg_wdata <= CFG_W'(gap);
    @(posedge clk_i);
    cfg_idx   <= CFG_LONG;
    cfg_wdata <= CFG_W'(lng);
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    cur_deb  = (deb > 40) ? 40 : deb;
    cur_gap  = (gap > 40) ? 40 : gap;
    cur_long = (lng > 40) ? 40 : lng;
    settings_loaded++;
  endtask

  initial begin
    int          budget, start, mode;
    int unsigned len;
    logic        pin;
    bit          paused;
    paused = 1'b0;
    pin    = 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Disabled after reset: presses are ignored
    send_ticks(1'b0, 3);
    wait_drain();

    // Zero debounce: long press, then release with no event
    load_settings(1'b1, 0, 2, 3);
    send_ticks(1'b0, 4);
    send_ticks(1'b1, 1);
    // Two quick clicks make a double
    send_ticks(1'b0, 1);
    send_ticks(1'b1, 1);
    send_ticks(1'b0, 1);
    send_ticks(1'b1, 1);
    // One click left alone times out as single
    send_ticks(1'b0, 1);
    send_ticks(1'b1, 4);
    wait_drain();

    // Zero long-press time fires on each press itself, so the releases give no single or double
    load_settings(1'b1, 0, 0, 0);
    send_ticks(1'b0, 1);
    send_ticks(1'b1, 1);
    send_ticks(1'b0, 1);
    send_ticks(1'b1, 2);
    wait_drain();

    // Disabled again: state frozen
    load_settings(1'b0, 0, 0, 0);
    send_ticks(1'b0, 2);
    wait_drain();

    // Random gesture phases
    for (int p = 0; p < NUM_PHASES; p++) begin
      mode = (p < 2) ? 0 : (p - 2) % 3 + 1;
      case (mode)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 60; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 60; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      budget = PHASE_TICKS;
      case (p)
        2: begin
          load_settings(1'b1, 1, 32767, 32767);
          budget = 150;
        end
        4: begin
          load_settings(1'b1, 32767, $urandom_range(0, 20), $urandom_range(1, 30));
          budget = 40;
        end
        5: begin
          load_settings(1'b0, $urandom_range(0, 4), $urandom_range(0, 20), $urandom_range(1, 30));
          budget = 40;
        end
        default:
          load_settings(1'b1, $urandom_range(0, 4), $urandom_range(0, 20), $urandom_range(1, 30));
      endcase
      // Back up the result side while the sender keeps going
      if (p == 1) hold_req <= hold_req + 1;
      start = ticks_sent;
      while (ticks_sent - start < budget) begin
        if (p == 3 && !paused && (ticks_sent - start) * 2 >= budget) begin
          wait_drain();
          paused = 1'b1;
        end
        pin = ~pin;
        case ($urandom_range(9))
          0, 1:          len = $urandom_range(cur_deb);                     // bounce
          2, 3, 4, 5, 6: len = cur_deb + $urandom_range(cur_gap + 2);       // click
          7, 8:          len = cur_deb + cur_long + $urandom_range(3);      // long hold
          default:       len = $urandom_range(1, 3);                        // noise
        endcase
        if (len == 0) len = 1;
        if (len > budget - (ticks_sent - start)) len = budget - (ticks_sent - start);
        send_ticks(pin, len);
      end
      wait_drain();
    end

    repeat (8) @(posedge clk_i);
    $display("ran %0d ticks over %0d register settings, with sender gaps, stalls and a hold-off",
             ticks_sent, settings_loaded);
    $display("checked %0d results: %0d single, %0d double, %0d long-press events",
             checked, singles, doubles, longs);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### button_click_classifier_core.f
+incdir+hdl
hdl/bcc_pkg.sv
hdl/bcc_cfg_regs.sv
hdl/bcc_classifier.sv
hdl/button_click_classifier_core.sv
bench/bcc_click_checker.sv
bench/button_click_classifier_core_tb.sv
